@@ sv/paf_pkg.sv @@
// ----------------------------------------------------------------------------
// paf_pkg: shared definitions for the partition allocator fit unit
// command, status, policy and register codes, default sizes, compare flags
// ----------------------------------------------------------------------------
package paf_pkg;

   localparam int MAX_PARTS_DEFAULT = 32;
   localparam int ADDR_BITS_DEFAULT = 20;

   typedef enum logic [1:0] {
      CMD_INIT  = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_ALLOC = 2'd2,
      CMD_FREE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOFIT    = 3'd1,
      ST_FULL     = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_BADMODE  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2,
      FIT_NONE  = 2'd3
   } policy_type;

   typedef enum logic [1:0] {
      CSR_SCHEME   = 2'd0,
      CSR_POLICY   = 2'd1,
      CSR_MEM_SIZE = 2'd2,
      CSR_SPARE    = 2'd3
   } csr_index_type;

   // flags from the shared compare unit
   typedef struct packed {
      logic take;    // free entry that fits and beats the current pick
      logic match;   // used entry whose start equals the requested base
   } cmp_out_type;

endpackage

@@ sv/partition_allocator_fit_unit.sv @@
// ----------------------------------------------------------------------------
// partition_allocator_fit_unit: first, best and worst fit partition allocator
// table of partitions in a memory, scanned and reshuffled by a sequencer
// ----------------------------------------------------------------------------
// Steps: an add reads the last entry unless the table is empty; allocate and
//   free scan the table; a dynamic allocate writes the pick for an exact fit,
//   else shifts the later entries up and splits the hole; a dynamic free adds
//   a merge pass.
// Throughput: one command at a time; the next one is taken once the sequencer
//   is idle, while a waiting result sits in the output register.
// Reset: entry count cleared, registers to dynamic, first fit, 1024 bytes;
//   table contents are not cleared.
module partition_allocator_fit_unit #(
   parameter int MAX_PARTS = paf_pkg::MAX_PARTS_DEFAULT,
   parameter int ADDR_BITS = paf_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic [ADDR_BITS:0]   req_request_size,
   input  logic [ADDR_BITS-1:0] req_base_address,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic [ADDR_BITS-1:0] rsp_granted_base,
   output logic [ADDR_BITS:0]   rsp_granted_size,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [ADDR_BITS:0]   csr_write_data
);

   import paf_pkg::*;

   localparam int SW = ADDR_BITS + 1;
   localparam int PW = $clog2(MAX_PARTS);
   localparam int CW = $clog2(MAX_PARTS + 1);
   localparam int EW = 2 * SW + 1;
   localparam logic [SW-1:0] SPACE = {1'b1, {ADDR_BITS{1'b0}}};
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_PARTS);

   typedef enum logic [3:0] {
      S_IDLE, S_ADD_RD, S_ADD_CHK, S_SCAN, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR,
      S_SPLIT_HI, S_SPLIT_LO, S_MRG_START, S_MRG_FIRST, S_MRG_RD, S_MRG_ACC,
      S_MRG_END, S_RESP
   } state_type;

   state_type        state_ff;
   logic [CW-1:0]    count_ff;
   logic             scheme_ff;
   policy_type       policy_ff;
   logic [SW-1:0]    mem_size_ff;
   cmd_type          cmd_ff;
   logic [SW-1:0]    req_ff;
   logic [ADDR_BITS-1:0] base_ff;
   logic [CW-1:0]    idx_ff;
   logic             found_ff;
   logic [PW-1:0]    pick_ff;
   logic [SW-1:0]    pick_start_ff;
   logic [SW-1:0]    pick_size_ff;
   logic [SW-1:0]    best_ff;
   logic [PW-1:0]    k_ff;
   logic [PW-1:0]    w_ff;
   logic [SW-1:0]    cur_start_ff;
   logic [SW-1:0]    cur_size_ff;
   logic             cur_free_ff;
   status_type       status_ff;
   logic [ADDR_BITS-1:0] gbase_ff;
   logic [SW-1:0]    gsize_ff;
   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   logic [ADDR_BITS-1:0] rsp_gbase_ff;
   logic [SW-1:0]    rsp_gsize_ff;

   logic             ram_we;
   logic [PW-1:0]    ram_waddr;
   logic [EW-1:0]    ram_wdata;
   logic [PW-1:0]    ram_raddr;
   logic [EW-1:0]    ram_rdata;
   logic [SW-1:0]    rd_start;
   logic [SW-1:0]    rd_size;
   logic             rd_free;
   logic [SW-1:0]    limit;
   logic [SW:0]      add_start;
   logic [SW-1:0]    cmp_rem;
   cmp_out_type      cmp_flags;
   logic             req_xfer;
   logic             rsp_xfer;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign {rd_start, rd_size, rd_free} = ram_rdata;
   assign limit = (mem_size_ff > SPACE) ? SPACE : mem_size_ff;
   assign add_start = (count_ff == '0) ? '0 : ({1'b0, rd_start} + {1'b0, rd_size});

   paf_table_ram #(
      .DEPTH(MAX_PARTS),
      .WIDTH(EW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   paf_fit_cmp #(
      .ADDR_BITS(ADDR_BITS)
   ) u_cmp (
      .ent_start (rd_start),
      .ent_size  (rd_size),
      .ent_free  (rd_free),
      .req_size  (req_ff),
      .base      (base_ff),
      .policy    (policy_ff),
      .found     (found_ff),
      .best      (best_ff),
      .rem       (cmp_rem),
      .flags     (cmp_flags)
   );

   // table memory port control
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer && cmd_type'(req_cmd) == CMD_INIT && scheme_ff && limit != '0) begin
               ram_we    = 1'b1;
               ram_wdata = {{SW{1'b0}}, limit, 1'b1};
            end
         end
         S_ADD_RD: ram_raddr = PW'(count_ff - 1'b1);
         S_ADD_CHK: begin
            if (!(add_start + {1'b0, req_ff} > {1'b0, limit})) begin
               ram_we    = 1'b1;
               ram_waddr = PW'(count_ff);
               ram_wdata = {add_start[SW-1:0], req_ff, 1'b1};
            end
         end
         S_SCAN:     ram_raddr = PW'(idx_ff);
         S_DECIDE: begin
            if (found_ff && (cmd_ff == CMD_FREE || !scheme_ff)) begin
               ram_we    = 1'b1;
               ram_waddr = pick_ff;
               ram_wdata = {pick_start_ff, pick_size_ff, cmd_ff == CMD_FREE};
            end
         end
         S_SHIFT_RD: ram_raddr = k_ff - 1'b1;
         S_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_waddr = k_ff;
            ram_wdata = ram_rdata;
         end
         S_SPLIT_HI: begin
            ram_we    = 1'b1;
            ram_waddr = pick_ff + 1'b1;
            ram_wdata = {pick_start_ff + req_ff, best_ff, 1'b1};
         end
         S_SPLIT_LO: begin
            ram_we    = 1'b1;
            ram_waddr = pick_ff;
            ram_wdata = {pick_start_ff, req_ff, 1'b0};
         end
         S_MRG_RD:   ram_raddr = PW'(idx_ff);
         S_MRG_ACC: begin
            if (!(cur_free_ff && rd_free)) begin
               ram_we    = 1'b1;
               ram_waddr = w_ff;
               ram_wdata = {cur_start_ff, cur_size_ff, cur_free_ff};
            end
         end
         S_MRG_END: begin
            ram_we    = 1'b1;
            ram_waddr = w_ff;
            ram_wdata = {cur_start_ff, cur_size_ff, cur_free_ff};
         end
         default: ;
      endcase
   end

   // sequencer, registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         scheme_ff    <= 1'b1;
         policy_ff    <= FIT_FIRST;
         mem_size_ff  <= SW'(1024);
         rsp_valid_ff <= 1'b0;
      end else begin
         // configuration writes
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_SCHEME:   scheme_ff   <= csr_write_data[0];
               CSR_POLICY:   policy_ff   <= policy_type'(csr_write_data[1:0]);
               CSR_MEM_SIZE: mem_size_ff <= csr_write_data;
               default: ;
            endcase
         end

         if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  cmd_ff    <= cmd_type'(req_cmd);
                  req_ff    <= req_request_size;
                  base_ff   <= req_base_address;
                  status_ff <= ST_OK;
                  gbase_ff  <= '0;
                  gsize_ff  <= '0;
                  idx_ff    <= '0;
                  found_ff  <= 1'b0;
                  state_ff  <= S_RESP;
                  case (cmd_type'(req_cmd))
                     CMD_INIT: begin
                        count_ff <= (scheme_ff && limit != '0) ? CW'(1) : '0;
                     end
                     CMD_ADD: begin
                        if (scheme_ff) begin
                           status_ff <= ST_BADMODE;
                        end else if (count_ff == FULL_COUNT) begin
                           status_ff <= ST_FULL;
                        end else if (count_ff == '0) begin
                           state_ff <= S_ADD_CHK;
                        end else begin
                           state_ff <= S_ADD_RD;
                        end
                     end
                     CMD_ALLOC: begin
                        if (req_request_size == '0) begin
                           status_ff <= ST_NOFIT;
                        end else begin
                           state_ff <= S_SCAN;
                        end
                     end
                     default: state_ff <= S_SCAN;
                  endcase
               end
            end
            S_ADD_RD: state_ff <= S_ADD_CHK;
            S_ADD_CHK: begin
               if (add_start + {1'b0, req_ff} > {1'b0, limit}) begin
                  status_ff <= ST_NOFIT;
               end else begin
                  count_ff <= count_ff + 1'b1;
                  gbase_ff <= add_start[ADDR_BITS-1:0];
                  gsize_ff <= req_ff;
               end
               state_ff <= S_RESP;
            end
            // one entry per cycle, data of entry idx-1 is on the read port
            S_SCAN: begin
               if (idx_ff != '0) begin
                  if ((cmd_ff == CMD_ALLOC && cmp_flags.take) ||
                      (cmd_ff == CMD_FREE && cmp_flags.match)) begin
                     found_ff      <= 1'b1;
                     pick_ff       <= PW'(idx_ff - 1'b1);
                     pick_start_ff <= rd_start;
                     pick_size_ff  <= rd_size;
                     best_ff       <= cmp_rem;
                  end
               end
               if (idx_ff == count_ff) begin
                  state_ff <= S_DECIDE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_DECIDE: begin
               state_ff <= S_RESP;
               if (cmd_ff == CMD_FREE) begin
                  if (!found_ff) begin
                     status_ff <= ST_NOTFOUND;
                  end else if (scheme_ff) begin
                     state_ff <= S_MRG_START;
                  end
               end else if (!found_ff) begin
                  status_ff <= ST_NOFIT;
               end else if (!scheme_ff) begin
                  gbase_ff <= pick_start_ff[ADDR_BITS-1:0];
                  gsize_ff <= pick_size_ff;
               end else if (best_ff != '0 && count_ff == FULL_COUNT) begin
                  status_ff <= ST_FULL;
               end else begin
                  gbase_ff <= pick_start_ff[ADDR_BITS-1:0];
                  gsize_ff <= req_ff;
                  k_ff     <= PW'(count_ff);
                  if (best_ff == '0) begin
                     state_ff <= S_SPLIT_LO;
                  end else if (count_ff > CW'(pick_ff) + 1'b1) begin
                     state_ff <= S_SHIFT_RD;
                  end else begin
                     state_ff <= S_SPLIT_HI;
                  end
               end
            end
            S_SHIFT_RD: state_ff <= S_SHIFT_WR;
            S_SHIFT_WR: begin
               k_ff <= k_ff - 1'b1;
               if (CW'(k_ff) - 1'b1 > CW'(pick_ff) + 1'b1) begin
                  state_ff <= S_SHIFT_RD;
               end else begin
                  state_ff <= S_SPLIT_HI;
               end
            end
            S_SPLIT_HI: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_SPLIT_LO;
            end
            S_SPLIT_LO: state_ff <= S_RESP;
            // merge pass: compact runs of free entries in place
            S_MRG_START: state_ff <= S_MRG_FIRST;
            S_MRG_FIRST: begin
               cur_start_ff <= rd_start;
               cur_size_ff  <= rd_size;
               cur_free_ff  <= rd_free;
               idx_ff       <= CW'(1);
               w_ff         <= '0;
               state_ff     <= (count_ff == CW'(1)) ? S_MRG_END : S_MRG_RD;
            end
            S_MRG_RD: state_ff <= S_MRG_ACC;
            S_MRG_ACC: begin
               if (cur_free_ff && rd_free) begin
                  cur_size_ff <= cur_size_ff + rd_size;
               end else begin
                  w_ff         <= w_ff + 1'b1;
                  cur_start_ff <= rd_start;
                  cur_size_ff  <= rd_size;
                  cur_free_ff  <= rd_free;
               end
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= (idx_ff + 1'b1 == count_ff) ? S_MRG_END : S_MRG_RD;
            end
            S_MRG_END: begin
               count_ff <= CW'(w_ff) + 1'b1;
               state_ff <= S_RESP;
            end
            // hand the result to the output register once it is free
            S_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_gbase_ff  <= gbase_ff;
                  rsp_gsize_ff  <= gsize_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_base = rsp_gbase_ff;
   assign rsp_granted_size = rsp_gsize_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond table depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff != S_IDLE)
      else $error("sequencer idle right after a transfer");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_gbase_ff == '0 && rsp_gsize_ff == '0)
      else $error("failed result carries a grant");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_status_ff <= ST_BADMODE)
      else $error("status code out of range");

endmodule

@@ sv/paf_table_ram.sv @@
// ----------------------------------------------------------------------------
// paf_table_ram: partition table storage
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module paf_table_ram #(
   parameter  int DEPTH = 32,
   parameter  int WIDTH = 43,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/paf_fit_cmp.sv @@
// ----------------------------------------------------------------------------
// paf_fit_cmp: shared subtract and compare unit
// remainder of one entry against the request, fit decision and base match
// ----------------------------------------------------------------------------
module paf_fit_cmp #(
   parameter  int ADDR_BITS = 20,
   localparam int SW        = ADDR_BITS + 1
) (
   input  logic [SW-1:0]          ent_start,
   input  logic [SW-1:0]          ent_size,
   input  logic                   ent_free,
   input  logic [SW-1:0]          req_size,
   input  logic [ADDR_BITS-1:0]   base,
   input  paf_pkg::policy_type    policy,
   input  logic                   found,
   input  logic [SW-1:0]          best,
   output logic [SW-1:0]          rem,
   output paf_pkg::cmp_out_type   flags
);

   import paf_pkg::*;

   logic fits;
   logic better;

   assign fits = ent_free && (ent_size >= req_size);
   assign rem  = ent_size - req_size;

   // policy compare, ties keep the earlier entry
   always_comb begin
      case (policy)
         FIT_FIRST: better = !found;
         FIT_BEST:  better = !found || (rem < best);
         FIT_WORST: better = !found || (rem > best);
         default:   better = 1'b0;
      endcase
   end

   assign flags.take  = fits && better;
   assign flags.match = !found && !ent_free && (ent_start == {1'b0, base});

endmodule

@@ bench/tb_partition_allocator_fit_unit.sv @@
// ----------------------------------------------------------------------------
// tb_partition_allocator_fit_unit: self-checking bench for the fit unit
// a queued driver feeds commands, a monitor checks each response against a
// table model kept in the bench, across schemes, fit policies and sizes
// ----------------------------------------------------------------------------
module tb_partition_allocator_fit_unit;
   import paf_pkg::*;

   localparam int NPARTS = 32;
   localparam int ABITS  = 20;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [1:0]     cmd;
      logic [ABITS:0] size;
      logic [ABITS-1:0] base;
   } command_item;

   typedef struct packed {
      logic [2:0]       status;
      logic [ABITS-1:0] base;
      logic [ABITS:0]   size;
   } grant_item;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_cmd = 0;
   logic [ABITS:0] req_request_size = 0;
   logic [ABITS-1:0] req_base_address = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [2:0] rsp_status;
   logic [ABITS-1:0] rsp_granted_base;
   logic [ABITS:0] rsp_granted_size;
   logic csr_write_enable = 0;
   logic [1:0] csr_index = 0;
   logic [ABITS:0] csr_write_data = 0;

   partition_allocator_fit_unit dut (.*);

   // clock
   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // bench copy of the table and registers
   logic          mdl_dynamic;
   logic [1:0]    mdl_policy;
   logic [ABITS:0] mdl_mem;
   longint        tbl_start [NPARTS];
   longint        tbl_size  [NPARTS];
   bit            tbl_free  [NPARTS];
   int            tbl_count;

   command_item pending_cmds[$];
   grant_item   expected_grants[$];
   int errors = 0, mismatches = 0, checked = 0;
   int send_idle = 0, recv_idle = 0;
   longint cycles = 0;
   int n_ok = 0, n_fail = 0;
   int last_base = 0;
   bit hold_go = 0;
   int hold_count = 0;
   logic hold_recv;

   assign hold_recv = hold_go && (hold_count < HOLD_CYCLES);

   function automatic longint mem_limit();
      return (mdl_mem > (1 << ABITS)) ? (1 << ABITS) : mdl_mem;
   endfunction

   function automatic void drop_entry(int idx);
      for (int k = idx; k + 1 < tbl_count; k++) begin
         tbl_start[k] = tbl_start[k+1];
         tbl_size[k]  = tbl_size[k+1];
         tbl_free[k]  = tbl_free[k+1];
      end
      tbl_count--;
   endfunction

   function automatic int pick_hole(longint req);
      int pick;
      bit found;
      longint best, rem;
      pick = tbl_count;
      found = 0;
      best = 0;
      for (int i = 0; i < tbl_count; i++) begin
         if (!tbl_free[i] || tbl_size[i] < req) continue;
         rem = tbl_size[i] - req;
         case (mdl_policy)
            FIT_FIRST: return i;
            FIT_BEST: if (!found || rem < best) begin
               pick = i; best = rem; found = 1;
            end
            FIT_WORST: if (!found || rem > best) begin
               pick = i; best = rem; found = 1;
            end
            default: return tbl_count;
         endcase
      end
      return pick;
   endfunction

   // predicted response for one command, updating the table copy
   function automatic grant_item predict_grant(command_item c);
      grant_item g;
      int i;
      longint start, rem, req;
      g = '0;
      g.status = ST_OK;
      req = c.size;
      case (c.cmd)
         CMD_INIT: begin
            tbl_count = 0;
            if (mdl_dynamic && mem_limit() > 0) begin
               tbl_start[0] = 0; tbl_size[0] = mem_limit(); tbl_free[0] = 1;
               tbl_count = 1;
            end
         end
         CMD_ADD: begin
            if (mdl_dynamic) g.status = ST_BADMODE;
            else if (tbl_count >= NPARTS) g.status = ST_FULL;
            else begin
               start = (tbl_count > 0) ?
                  tbl_start[tbl_count-1] + tbl_size[tbl_count-1] : 0;
               if (start + req > mem_limit()) g.status = ST_NOFIT;
               else begin
                  tbl_start[tbl_count] = start;
                  tbl_size[tbl_count] = req;
                  tbl_free[tbl_count] = 1;
                  tbl_count++;
                  g.base = start[ABITS-1:0]; g.size = req[ABITS:0];
               end
            end
         end
         CMD_ALLOC: begin
            i = (req == 0) ? tbl_count : pick_hole(req);
            if (i >= tbl_count) g.status = ST_NOFIT;
            else if (!mdl_dynamic) begin
               tbl_free[i] = 0;
               g.base = tbl_start[i][ABITS-1:0]; g.size = tbl_size[i][ABITS:0];
            end else begin
               rem = tbl_size[i] - req;
               if (rem > 0 && tbl_count >= NPARTS) g.status = ST_FULL;
               else begin
                  if (rem > 0) begin
                     for (int k = tbl_count; k > i + 1; k--) begin
                        tbl_start[k] = tbl_start[k-1];
                        tbl_size[k]  = tbl_size[k-1];
                        tbl_free[k]  = tbl_free[k-1];
                     end
                     tbl_start[i+1] = tbl_start[i] + req;
                     tbl_size[i+1] = rem;
                     tbl_free[i+1] = 1;
                     tbl_count++;
                  end
                  tbl_size[i] = req; tbl_free[i] = 0;
                  g.base = tbl_start[i][ABITS-1:0]; g.size = req[ABITS:0];
               end
            end
         end
         default: begin
            g.status = ST_NOTFOUND;
            for (i = 0; i < tbl_count; i++) begin
               if (tbl_start[i] == c.base && !tbl_free[i]) begin
                  tbl_free[i] = 1;
                  g.status = ST_OK;
                  if (mdl_dynamic) begin
                     int j;
                     j = 0;
                     while (j + 1 < tbl_count) begin
                        if (tbl_free[j] && tbl_free[j+1]) begin
                           tbl_size[j] += tbl_size[j+1];
                           drop_entry(j + 1);
                        end else j++;
                     end
                  end
                  break;
               end
            end
         end
      endcase
      return g;
   endfunction

   // driver: present the next pending command, hold it while stalled
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) req_valid <= 0;
      else if (!req_valid || !req_stall) begin
         if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
            command_item c;
            c = pending_cmds.pop_front();
            expected_grants.push_back(predict_grant(c));
            req_valid <= 1;
            req_cmd <= c.cmd;
            req_request_size <= c.size;
            req_base_address <= c.base;
         end else req_valid <= 0;
      end
   end

   // long receiver hold-off, counted here once started
   always @(posedge clock) begin
      if (hold_recv) hold_count <= hold_count + 1;
   end

   // receiver stall
   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else rsp_stall <= hold_recv || ($urandom_range(99) < recv_idle);
   end

   // monitor: compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         grant_item g;
         last_base = int'(rsp_granted_base);
         if (expected_grants.size() == 0) begin
            errors++;
            if (mismatches++ < 10) $display("unexpected response status %0d", rsp_status);
         end else begin
            g = expected_grants.pop_front();
            checked++;
            if (g.status == ST_OK) n_ok++; else n_fail++;
            if (rsp_status !== g.status || rsp_granted_base !== g.base ||
                rsp_granted_size !== g.size) begin
               errors++;
               if (mismatches++ < 10)
                  $display("mismatch: expected st %0d base %0d size %0d, got st %0d base %0d size %0d",
                     g.status, g.base, g.size, rsp_status, rsp_granted_base,
                     rsp_granted_size);
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", expected_grants.size());
         $display("FAIL partition_allocator_fit_unit");
         $finish;
      end
   end

   task automatic wait_idle();
      while (pending_cmds.size() > 0 || expected_grants.size() > 0 || req_valid)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic wait_idle_light();
      while (pending_cmds.size() > 0 || expected_grants.size() > 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int value);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= value[ABITS:0];
      @(posedge clock);
      csr_write_enable <= 0;
      case (idx)
         CSR_SCHEME:   mdl_dynamic = value[0];
         CSR_POLICY:   mdl_policy = value[1:0];
         CSR_MEM_SIZE: mdl_mem = value[ABITS:0];
         default: ;
      endcase
   endtask

   function automatic void queue_cmd(cmd_type c, int sz, int b);
      command_item it;
      it.cmd = c; it.size = sz[ABITS:0]; it.base = b[ABITS-1:0];
      pending_cmds.push_back(it);
   endfunction

   // a random burst: inits, adds, allocs and frees at likely or random bases
   task automatic random_phase(int n);
      int sz, pick, mask;
      mask = $urandom_range(3);
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         sz = (mask == 0) ? $urandom_range(64) :
              (mask == 1) ? $urandom_range(mdl_mem > 0 ? mdl_mem : 1) :
              $urandom_range(2097151);
         if (pick < 4) queue_cmd(CMD_INIT, $urandom, $urandom);
         else if (pick < 20) queue_cmd(CMD_ADD, sz, $urandom);
         else if (pick < 60) queue_cmd(CMD_ALLOC, sz, $urandom);
         else if (pick < 95) begin
            // free at a base a recent alloc could have returned
            queue_cmd(CMD_FREE, $urandom, (mask == 0) ? $urandom_range(64) * $urandom_range(16)
                                          : $urandom_range(1048575));
         end else queue_cmd(CMD_FREE, $urandom, $urandom);
      end
   endtask

   // frees driven from actual grants need feedback, so a tracked phase runs
   // each allocate before choosing its free base
   task automatic tracked_phase(int n);
      command_item c;
      int used[$];
      for (int k = 0; k < n; k++) begin
         if (used.size() > 0 && $urandom_range(1)) begin
            int j;
            j = $urandom_range(used.size() - 1);
            queue_cmd(CMD_FREE, 0, used[j]);
            used.delete(j);
         end else queue_cmd(CMD_ALLOC, $urandom_range(1, 80), 0);
         c = pending_cmds[pending_cmds.size()-1];
         wait_idle_light();
         if (c.cmd == CMD_ALLOC) used.push_back(last_base);
      end
   endtask

   initial begin
      mdl_dynamic = 1; mdl_policy = FIT_FIRST; mdl_mem = 1024; tbl_count = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      send_idle = 33; recv_idle = 65;

      // directed: dynamic defaults
      queue_cmd(CMD_ALLOC, 10, 0);          // table empty after reset
      queue_cmd(CMD_INIT, 0, 0);
      queue_cmd(CMD_ADD, 5, 0);             // bad mode
      queue_cmd(CMD_ALLOC, 0, 0);           // zero size
      queue_cmd(CMD_ALLOC, 100, 0);
      queue_cmd(CMD_ALLOC, 2097151, 0);
      queue_cmd(CMD_ALLOC, 924, 0);         // exact fit of the rest
      queue_cmd(CMD_FREE, 0, 1048575);      // unknown base
      queue_cmd(CMD_FREE, 0, 0);
      queue_cmd(CMD_FREE, 0, 100);          // merge
      wait_idle();
      write_reg(CSR_POLICY, FIT_NONE);
      queue_cmd(CMD_ALLOC, 1, 0);
      wait_idle();
      // fixed mode with the largest memory
      write_reg(CSR_SCHEME, 0);
      write_reg(CSR_MEM_SIZE, 1 << 20);
      write_reg(CSR_POLICY, FIT_WORST);
      queue_cmd(CMD_INIT, 0, 0);
      queue_cmd(CMD_ADD, 0, 0);
      queue_cmd(CMD_ADD, 1000, 0);
      queue_cmd(CMD_ADD, 2097151, 0);       // past the end
      queue_cmd(CMD_ADD, 1047576, 0);       // to the very end
      queue_cmd(CMD_ALLOC, 1000, 0);
      queue_cmd(CMD_FREE, 0, 1000);
      wait_idle();
      // zero memory and oversized register
      write_reg(CSR_SCHEME, 1);
      write_reg(CSR_MEM_SIZE, 0);
      queue_cmd(CMD_INIT, 0, 0);
      queue_cmd(CMD_ALLOC, 1, 0);
      wait_idle();
      write_reg(CSR_MEM_SIZE, 2097151);
      queue_cmd(CMD_INIT, 0, 0);
      queue_cmd(CMD_ALLOC, 1048576, 0);
      wait_idle();

      // table full and proper free patterns in dynamic mode
      write_reg(CSR_MEM_SIZE, 1024);
      write_reg(CSR_POLICY, FIT_FIRST);
      queue_cmd(CMD_INIT, 0, 0);
      tracked_phase(60);
      wait_idle();

      // receiver held off while the sender keeps offering
      hold_go = 1;
      for (int k = 0; k < 12; k++) queue_cmd(CMD_ALLOC, $urandom_range(1, 20), 0);
      wait (hold_count == HOLD_CYCLES);
      wait_idle();

      // random phases over several settings
      for (int p = 0; p < 12; p++) begin
         if (p == 4) begin send_idle = 65; recv_idle = 33; end
         if (p == 8) begin send_idle = 0; recv_idle = 0; end
         write_reg(CSR_SCHEME, $urandom_range(1));
         write_reg(CSR_POLICY, $urandom_range(3));
         write_reg(CSR_MEM_SIZE, (p % 3 == 0) ? $urandom_range(1, 200) :
                   (p % 3 == 1) ? $urandom_range(1, 2097151) : 1024);
         queue_cmd(CMD_INIT, 0, 0);
         if (p % 2) tracked_phase(25);
         random_phase(57);
         wait_idle();
      end

      $display("checked %0d responses (%0d ok, %0d refused) over fixed and dynamic",
               checked, n_ok, n_fail);
      $display("schemes, all fit policies and memory sizes from zero to the clamp");
      if (errors == 0 && expected_grants.size() == 0)
         $display("PASS partition_allocator_fit_unit");
      else
         $display("FAIL partition_allocator_fit_unit");
      $finish;
   end

endmodule

@@ partition_allocator_fit_unit.f @@
sv/paf_pkg.sv
sv/paf_table_ram.sv
sv/paf_fit_cmp.sv
sv/partition_allocator_fit_unit.sv
bench/tb_partition_allocator_fit_unit.sv
